@@ src/lcgl_pkg.sv @@
// lcgl_pkg: shared types, label codes and register defaults for the column ground labeler
// no dependencies
package lcgl_pkg;

    localparam int COLUMN_DEPTH_DEF              = 64;
    localparam int TERRAIN_MODE_DEF              = 0;
    localparam int TERRAIN_MAX_STEP_MM_DEF       = 5000;
    localparam int GROUND_UPDATE_MAX_STEP_MM_DEF = 1000;

    typedef logic [3:0] label_t;

    localparam label_t LBL_FLAT         = 4'd0;
    localparam label_t LBL_FLAT_AFTER   = 4'd1;
    localparam label_t LBL_NEAR_GROUND  = 4'd2;
    localparam label_t LBL_OBSTACLE     = 4'd3;
    localparam label_t LBL_RELABELLED   = 4'd4;
    localparam label_t LBL_FIRST_GROUND = 4'd5;
    localparam label_t LBL_FIRST_OBST   = 4'd6;
    localparam label_t LBL_EGO          = 4'd7;
    localparam label_t LBL_SKIPPED      = 4'd8;

    localparam logic [2:0] REG_GROUND_HEIGHT  = 3'd0;
    localparam logic [2:0] REG_SLOPE_LIMIT    = 3'd1;
    localparam logic [2:0] REG_FR_MIN_DZ      = 3'd2;
    localparam logic [2:0] REG_FR_MAX_DZ      = 3'd3;
    localparam logic [2:0] REG_NG_RANGE       = 3'd4;
    localparam logic [2:0] REG_NG_HEIGHT      = 3'd5;
    localparam logic [2:0] REG_SPREAD_RANGE   = 3'd6;
    localparam logic [2:0] REG_UPD_MIN_SLOPE  = 3'd7;

    localparam logic [13:0] GROUND_HEIGHT_RST = 14'h3830;
    localparam logic [15:0] SLOPE_LIMIT_RST   = 16'd64;
    localparam logic [13:0] FR_MIN_DZ_RST     = 14'h3ED4;
    localparam logic [13:0] FR_MAX_DZ_RST     = 14'd300;
    localparam logic [15:0] NG_RANGE_RST      = 16'd500;
    localparam logic [15:0] NG_HEIGHT_RST     = 16'd150;
    localparam logic [15:0] SPREAD_RANGE_RST  = 16'd300;
    localparam logic [15:0] UPD_MIN_SLOPE_RST = 16'hFFC0;

    typedef struct packed {
        logic [13:0] ground_height;
        logic [15:0] slope_limit;
        logic [13:0] fr_min_dz;
        logic [13:0] fr_max_dz;
        logic [15:0] ng_range;
        logic [15:0] ng_height;
        logic [15:0] spread_range;
        logic [15:0] upd_min_slope;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic mul;
        logic decide;
        logic walk_rd;
        logic relabel;
    } cmd_t;

    typedef struct packed {
        logic walk;
        logic match;
        logic walk_end;
    } status_t;

endpackage

@@ src/lcgl_datapath.sv @@
// lcgl_datapath: column state, slope products, label decision and the column store
// depends on lcgl_pkg
module lcgl_datapath #(
    parameter int COLUMN_DEPTH              = lcgl_pkg::COLUMN_DEPTH_DEF,
    parameter int TERRAIN_MODE              = lcgl_pkg::TERRAIN_MODE_DEF,
    parameter int TERRAIN_MAX_STEP_MM       = lcgl_pkg::TERRAIN_MAX_STEP_MM_DEF,
    parameter int GROUND_UPDATE_MAX_STEP_MM = lcgl_pkg::GROUND_UPDATE_MAX_STEP_MM_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcgl_pkg::cfg_t        cfg,
    input  lcgl_pkg::cmd_t        cmd,
    input  logic [17:0]           in_range,
    input  logic [16:0]           in_height,
    input  logic                  in_invalid,
    input  logic                  in_ego,
    input  logic                  in_column_start,
    output lcgl_pkg::status_t     status,
    output logic [5:0]            out_pos,
    output lcgl_pkg::label_t      out_label,
    output logic                  out_ignored
);

    localparam int AW  = $clog2(COLUMN_DEPTH);
    localparam int CW  = $clog2(COLUMN_DEPTH + 1);

    logic [21:0] store_mem [COLUMN_DEPTH];
    logic [21:0] rdata_reg;

    logic [17:0] r_reg;
    logic [16:0] h_reg;
    logic        inv_reg;
    logic        ego_reg;

    logic [CW-1:0]    rc_reg;
    logic [17:0]      prev_range_reg;
    logic [16:0]      prev_height_reg;
    lcgl_pkg::label_t prev_label_reg;
    logic [17:0]      ground_range_reg;
    logic [16:0]      ground_height_reg;
    logic             found_reg;
    logic             obst_reg;

    logic [AW-1:0] pos_reg;
    logic [AW-1:0] walk_idx_reg;

    logic signed [18:0] dx_reg, gx_reg;
    logic signed [17:0] dz_reg, gz_reg;
    logic signed [35:0] prod_prev_reg, prod_gnd_reg;
    logic signed [34:0] prod_upd_reg;

    logic [5:0]       out_pos_reg;
    lcgl_pkg::label_t out_label_reg;
    logic             out_ignored_reg;

    // decision
    logic [17:0] abs_dz, abs_gz, abs_dx, abs_gx;
    logic        fprev, fgnd, near_gnd, upd_ok, first_in_band;
    logic signed [17:0] hop;
    lcgl_pkg::label_t lbl;
    logic        skip_pt;
    logic [17:0] er, abs_er;
    lcgl_pkg::label_t el;

    always_comb
    begin
        abs_dz = dz_reg[17] ? 18'(-dz_reg) : 18'(dz_reg);
        abs_gz = gz_reg[17] ? 18'(-gz_reg) : 18'(gz_reg);
        abs_dx = dx_reg[18] ? 18'(-dx_reg) : 18'(dx_reg);
        abs_gx = gx_reg[18] ? 18'(-gx_reg) : 18'(gx_reg);
        fprev = (dx_reg > 19'sd0) && ($signed({10'b0, abs_dz, 8'b0}) < prod_prev_reg);
        if (TERRAIN_MODE != 0)
            fprev = fprev && (dx_reg[17:0] < 18'(TERRAIN_MAX_STEP_MM));
        fgnd = (gx_reg > 19'sd0) && ($signed({10'b0, abs_gz, 8'b0}) < prod_gnd_reg);
        near_gnd = (abs_gx < {2'b0, cfg.ng_range}) && (abs_gz < {2'b0, cfg.ng_height});
        upd_ok = ($signed({{9{dz_reg[17]}}, dz_reg, 8'b0}) > prod_upd_reg)
            && (abs_dx < 18'(GROUND_UPDATE_MAX_STEP_MM))
            && (prev_label_reg != lcgl_pkg::LBL_NEAR_GROUND);
        hop = $signed({h_reg[16], h_reg})
            - $signed({{4{cfg.ground_height[13]}}, cfg.ground_height});
        first_in_band = (hop > $signed({{4{cfg.fr_min_dz[13]}}, cfg.fr_min_dz}))
            && (hop < $signed({{4{cfg.fr_max_dz[13]}}, cfg.fr_max_dz}));
        skip_pt = inv_reg || ego_reg;
        if (inv_reg)
            lbl = lcgl_pkg::LBL_SKIPPED;
        else if (ego_reg)
            lbl = lcgl_pkg::LBL_EGO;
        else if (!found_reg)
            lbl = first_in_band ? lcgl_pkg::LBL_FIRST_GROUND : lcgl_pkg::LBL_FIRST_OBST;
        else if (!obst_reg && fprev)
            lbl = lcgl_pkg::LBL_FLAT;
        else if (obst_reg && fprev && fgnd)
            lbl = lcgl_pkg::LBL_FLAT_AFTER;
        else if (near_gnd)
            lbl = lcgl_pkg::LBL_NEAR_GROUND;
        else
            lbl = lcgl_pkg::LBL_OBSTACLE;

        el = rdata_reg[21:18];
        er = rdata_reg[17:0];
        abs_er = (r_reg >= er) ? (r_reg - er) : (er - r_reg);
        status.walk = (lbl == lcgl_pkg::LBL_OBSTACLE) && (pos_reg != '0);
        status.match = (el == lcgl_pkg::LBL_NEAR_GROUND)
            || (((el == lcgl_pkg::LBL_FLAT) || (el == lcgl_pkg::LBL_FLAT_AFTER)
                 || (el == lcgl_pkg::LBL_FIRST_GROUND))
                && (abs_er < {2'b0, cfg.spread_range}));
        status.walk_end = (walk_idx_reg == '0);
    end

    // payload and arithmetic pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg   <= in_range;
            h_reg   <= in_height;
            inv_reg <= in_invalid;
            ego_reg <= in_ego;
        end
        if (cmd.diff)
        begin
            dx_reg <= $signed({1'b0, r_reg}) - $signed({1'b0, prev_range_reg});
            gx_reg <= $signed({1'b0, r_reg}) - $signed({1'b0, ground_range_reg});
            dz_reg <= $signed({h_reg[16], h_reg}) - $signed({prev_height_reg[16], prev_height_reg});
            gz_reg <= $signed({h_reg[16], h_reg})
                - $signed({ground_height_reg[16], ground_height_reg});
        end
        if (cmd.mul)
        begin
            prod_prev_reg <= $signed({1'b0, cfg.slope_limit}) * dx_reg;
            prod_gnd_reg  <= $signed({1'b0, cfg.slope_limit}) * gx_reg;
            prod_upd_reg  <= $signed(cfg.upd_min_slope) * dx_reg;
        end
        if (cmd.decide)
        begin
            store_mem[pos_reg] <= {lbl, r_reg};
            out_pos_reg     <= 6'(pos_reg);
            out_label_reg   <= lbl;
            out_ignored_reg <= !((lbl == lcgl_pkg::LBL_OBSTACLE)
                                 || (lbl == lcgl_pkg::LBL_FIRST_OBST));
            walk_idx_reg    <= pos_reg - AW'(1);
        end
        else if (cmd.relabel)
        begin
            store_mem[walk_idx_reg] <= {lcgl_pkg::LBL_RELABELLED, rdata_reg[17:0]};
            out_pos_reg     <= 6'(walk_idx_reg);
            out_label_reg   <= lcgl_pkg::LBL_RELABELLED;
            out_ignored_reg <= 1'b1;
            walk_idx_reg    <= walk_idx_reg - AW'(1);
        end
        if (cmd.walk_rd)
            rdata_reg <= store_mem[walk_idx_reg];
        if (cmd.diff)
            pos_reg <= (rc_reg < CW'(COLUMN_DEPTH)) ? rc_reg[AW-1:0] : AW'(COLUMN_DEPTH - 1);
    end

    // per-column state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg            <= '0;
            prev_range_reg    <= '0;
            prev_height_reg   <= '0;
            prev_label_reg    <= lcgl_pkg::LBL_FLAT;
            ground_range_reg  <= '0;
            ground_height_reg <= {{3{lcgl_pkg::GROUND_HEIGHT_RST[13]}},
                                  lcgl_pkg::GROUND_HEIGHT_RST};
            found_reg         <= 1'b0;
            obst_reg          <= 1'b0;
        end
        else if (cmd.load && in_column_start)
        begin
            rc_reg            <= '0;
            prev_range_reg    <= '0;
            prev_height_reg   <= '0;
            prev_label_reg    <= lcgl_pkg::LBL_FLAT;
            ground_range_reg  <= '0;
            ground_height_reg <= {{3{cfg.ground_height[13]}}, cfg.ground_height};
            found_reg         <= 1'b0;
            obst_reg          <= 1'b0;
        end
        else if (cmd.diff)
        begin
            if (rc_reg < CW'(COLUMN_DEPTH))
                rc_reg <= rc_reg + CW'(1);
        end
        else if (cmd.decide && !skip_pt)
        begin
            prev_range_reg  <= r_reg;
            prev_height_reg <= h_reg;
            prev_label_reg  <= lbl;
            found_reg       <= 1'b1;
            case (lbl) inside
                lcgl_pkg::LBL_FIRST_GROUND:
                begin
                    ground_range_reg  <= r_reg;
                    ground_height_reg <= h_reg;
                    obst_reg          <= 1'b0;
                end
                lcgl_pkg::LBL_FIRST_OBST, lcgl_pkg::LBL_OBSTACLE:
                    obst_reg <= 1'b1;
                lcgl_pkg::LBL_FLAT, lcgl_pkg::LBL_FLAT_AFTER:
                begin
                    if (upd_ok)
                    begin
                        ground_range_reg  <= r_reg;
                        ground_height_reg <= h_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign out_pos     = out_pos_reg;
    assign out_label   = out_label_reg;
    assign out_ignored = out_ignored_reg;

endmodule

@@ src/lcgl_ctrl.sv @@
// lcgl_ctrl: sequencer for one point, the walk back down the store and the output handshake
// depends on lcgl_pkg
module lcgl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    input  lcgl_pkg::status_t status,
    output lcgl_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_DECIDE,
        S_RD,
        S_CHK,
        S_HOLD
    } state_t;

    state_t state_reg;
    logic   out_vld_reg;
    logic   out_last_reg;
    logic   out_set;
    logic   out_set_last;

    always_comb
    begin
        s_tready    = (state_reg == S_IDLE);
        cmd.load    = s_tvalid && (state_reg == S_IDLE);
        cmd.diff    = (state_reg == S_DIFF);
        cmd.mul     = (state_reg == S_MUL);
        cmd.decide  = (state_reg == S_DECIDE) && (!out_vld_reg || m_tready);
        cmd.walk_rd = (state_reg == S_RD);
        cmd.relabel = (state_reg == S_HOLD) && m_tready;
        out_set = ((state_reg == S_DECIDE) && cmd.decide && !status.walk)
            || (state_reg == S_CHK)
            || ((state_reg == S_HOLD) && m_tready && status.walk_end);
        // the pending item goes out once we know whether another follows
        out_set_last = (state_reg == S_CHK) ? !status.match : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_vld_reg  <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (out_set)
            begin
                out_vld_reg  <= 1'b1;
                out_last_reg <= out_set_last;
            end
            else if (out_vld_reg && m_tready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                        state_reg <= S_DIFF;
                S_DIFF:
                    state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_DECIDE;
                S_DECIDE:
                    if (cmd.decide)
                        state_reg <= status.walk ? S_RD : S_IDLE;
                S_RD:
                    state_reg <= S_CHK;
                S_CHK:
                    state_reg <= status.match ? S_HOLD : S_IDLE;
                S_HOLD:
                    if (m_tready)
                        state_reg <= status.walk_end ? S_IDLE : S_RD;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ src/lidar_column_ground_labeler.sv @@
// lidar_column_ground_labeler: top level with register file, controller and datapath
// depends on lcgl_pkg, lcgl_ctrl, lcgl_datapath
// sequence: each point runs diff, mul and decide states; an obstacle walk then reads the
// single-port store back down the column, checking and relabelling one earlier point at a time
// new points are taken only in idle, after any walk; output stalls hold decide and walk
// reset: async active low, registers to defaults, column state cleared, store left as is
module lidar_column_ground_labeler #(
    parameter int COLUMN_DEPTH              = lcgl_pkg::COLUMN_DEPTH_DEF,
    parameter int TERRAIN_MODE              = lcgl_pkg::TERRAIN_MODE_DEF,
    parameter int TERRAIN_MAX_STEP_MM       = lcgl_pkg::TERRAIN_MAX_STEP_MM_DEF,
    parameter int GROUND_UPDATE_MAX_STEP_MM = lcgl_pkg::GROUND_UPDATE_MAX_STEP_MM_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // horizontal_range[17:0], height[34:18], zero pad
    input  logic [2:0]  s_tuser,   // is_invalid[0], in_ego_box[1], column_start[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // row_position[5:0], label[9:6], ignored[10], zero pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lcgl_pkg::cfg_t    cfg_reg;
    lcgl_pkg::cmd_t    cmd;
    lcgl_pkg::status_t status;
    logic [5:0]        out_pos;
    lcgl_pkg::label_t  out_label;
    logic              out_ignored;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ground_height <= lcgl_pkg::GROUND_HEIGHT_RST;
            cfg_reg.slope_limit   <= lcgl_pkg::SLOPE_LIMIT_RST;
            cfg_reg.fr_min_dz     <= lcgl_pkg::FR_MIN_DZ_RST;
            cfg_reg.fr_max_dz     <= lcgl_pkg::FR_MAX_DZ_RST;
            cfg_reg.ng_range      <= lcgl_pkg::NG_RANGE_RST;
            cfg_reg.ng_height     <= lcgl_pkg::NG_HEIGHT_RST;
            cfg_reg.spread_range  <= lcgl_pkg::SPREAD_RANGE_RST;
            cfg_reg.upd_min_slope <= lcgl_pkg::UPD_MIN_SLOPE_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                lcgl_pkg::REG_GROUND_HEIGHT: cfg_reg.ground_height <= pwdata[13:0];
                lcgl_pkg::REG_SLOPE_LIMIT:   cfg_reg.slope_limit   <= pwdata[15:0];
                lcgl_pkg::REG_FR_MIN_DZ:     cfg_reg.fr_min_dz     <= pwdata[13:0];
                lcgl_pkg::REG_FR_MAX_DZ:     cfg_reg.fr_max_dz     <= pwdata[13:0];
                lcgl_pkg::REG_NG_RANGE:      cfg_reg.ng_range      <= pwdata[15:0];
                lcgl_pkg::REG_NG_HEIGHT:     cfg_reg.ng_height     <= pwdata[15:0];
                lcgl_pkg::REG_SPREAD_RANGE:  cfg_reg.spread_range  <= pwdata[15:0];
                lcgl_pkg::REG_UPD_MIN_SLOPE: cfg_reg.upd_min_slope <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lcgl_pkg::REG_GROUND_HEIGHT: prdata = {18'b0, cfg_reg.ground_height};
            lcgl_pkg::REG_SLOPE_LIMIT:   prdata = {16'b0, cfg_reg.slope_limit};
            lcgl_pkg::REG_FR_MIN_DZ:     prdata = {18'b0, cfg_reg.fr_min_dz};
            lcgl_pkg::REG_FR_MAX_DZ:     prdata = {18'b0, cfg_reg.fr_max_dz};
            lcgl_pkg::REG_NG_RANGE:      prdata = {16'b0, cfg_reg.ng_range};
            lcgl_pkg::REG_NG_HEIGHT:     prdata = {16'b0, cfg_reg.ng_height};
            lcgl_pkg::REG_SPREAD_RANGE:  prdata = {16'b0, cfg_reg.spread_range};
            lcgl_pkg::REG_UPD_MIN_SLOPE: prdata = {16'b0, cfg_reg.upd_min_slope};
            default:                     prdata = 32'b0;
        endcase
    end

    lcgl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    lcgl_datapath #(
        .COLUMN_DEPTH              (COLUMN_DEPTH),
        .TERRAIN_MODE              (TERRAIN_MODE),
        .TERRAIN_MAX_STEP_MM       (TERRAIN_MAX_STEP_MM),
        .GROUND_UPDATE_MAX_STEP_MM (GROUND_UPDATE_MAX_STEP_MM)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .in_range        (s_tdata[17:0]),
        .in_height       (s_tdata[34:18]),
        .in_invalid      (s_tuser[0]),
        .in_ego          (s_tuser[1]),
        .in_column_start (s_tuser[2]),
        .status          (status),
        .out_pos         (out_pos),
        .out_label       (out_label),
        .out_ignored     (out_ignored)
    );

    assign m_tdata = {5'b0, out_ignored, out_label, out_pos};

endmodule
